### rtl/min_end_removals_to_target_top_defines.svh
// assertion macros for the min end removals block
// no dependencies; included by the top level
`ifndef MIN_END_REMOVALS_TO_TARGET_TOP_DEFINES_SVH
`define MIN_END_REMOVALS_TO_TARGET_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define MERT_ASSERT_CLK(lbl, clk_s, rstn_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) \
    else $error("min end removals check failed");
`define MERT_ASSERT(lbl, prop) `MERT_ASSERT_CLK(lbl, clk, rst_n, prop)
`else
`define MERT_ASSERT_CLK(lbl, clk_s, rstn_s, prop)
`define MERT_ASSERT(lbl, prop)
`endif
`endif

### rtl/mert_pkg.sv
// shared types and constants for the min end removals block
// no dependencies; used by controller, datapath and top level
package mert_pkg;

  localparam int MAX_LEN_DEF    = 1024;
  localparam int VALUE_BITS_DEF = 14;
  localparam int TARGET_W       = 30;

  // result status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_IMPOSSIBLE = 2'd1;
  localparam logic [1:0] ST_OVERFLOW   = 2'd2;

  // config register index
  localparam logic REG_TARGET = 1'b0;

  typedef enum logic [1:0] {
    EMIT_OVF,
    EMIT_IMP,
    EMIT_ALL,
    EMIT_WALK
  } emit_kind_t;

  typedef struct packed {
    logic       store;
    logic       init;
    logic       add;
    logic       shrink_rd;
    logic       shrink;
    logic       advance;
    logic       emit;
    emit_kind_t kind;
  } mert_cmd_t;

  typedef struct packed {
    logic overflow;
    logic total_lt;
    logic total_eq;
    logic shrink_needed;
    logic end_last;
    logic out_free;
  } mert_sts_t;

endpackage

### rtl/mert_ctrl.sv
// sequencer for load, decision and window walk
// depends on mert_pkg
module mert_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tlast,
  output logic              in_tready,
  input  mert_pkg::mert_sts_t sts,
  output mert_pkg::mert_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_LOAD,
    S_DECIDE,
    S_ADD,
    S_CHK,
    S_SHRINK,
    S_EMIT
  } state_t;

  state_t                 state_r, state_nxt;
  mert_pkg::emit_kind_t   kind_r, kind_nxt;

  always_comb begin
    state_nxt = state_r;
    kind_nxt  = kind_r;
    cmd       = '0;
    cmd.kind  = kind_r;
    in_tready = 1'b0;
    case (state_r)
      S_LOAD: begin
        in_tready = 1'b1;
        cmd.store = in_tvalid;
        if (in_tvalid && in_tlast) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts.overflow) begin
          kind_nxt  = mert_pkg::EMIT_OVF;
          state_nxt = S_EMIT;
        end else if (sts.total_lt) begin
          kind_nxt  = mert_pkg::EMIT_IMP;
          state_nxt = S_EMIT;
        end else if (sts.total_eq) begin
          kind_nxt  = mert_pkg::EMIT_ALL;
          state_nxt = S_EMIT;
        end else begin
          cmd.init  = 1'b1;
          state_nxt = S_ADD;
        end
      end
      S_ADD: begin
        cmd.add   = 1'b1;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (sts.shrink_needed) begin
          cmd.shrink_rd = 1'b1;
          state_nxt     = S_SHRINK;
        end else begin
          cmd.advance = 1'b1;
          if (sts.end_last) begin
            kind_nxt  = mert_pkg::EMIT_WALK;
            state_nxt = S_EMIT;
          end else begin
            state_nxt = S_ADD;
          end
        end
      end
      S_SHRINK: begin
        cmd.shrink = 1'b1;
        state_nxt  = S_CHK;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_LOAD;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      kind_r  <= mert_pkg::EMIT_IMP;
    end else begin
      state_r <= state_nxt;
      kind_r  <= kind_nxt;
    end
  end

endmodule

### rtl/mert_dp.sv
// element store, totals, sliding window and result register
// depends on mert_pkg
module mert_dp #(
  parameter int MAX_LEN    = mert_pkg::MAX_LEN_DEF,
  parameter int VALUE_BITS = mert_pkg::VALUE_BITS_DEF,
  localparam int CNT_W     = $clog2(MAX_LEN + 1),
  localparam int ADDR_W    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mert_pkg::mert_cmd_t           cmd,
  output mert_pkg::mert_sts_t           sts,
  input  logic [VALUE_BITS-1:0]         element_value,
  input  logic [mert_pkg::TARGET_W-1:0] target_removal,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_status,
  output logic [CNT_W-1:0]              out_removals
);

  localparam int SUM_W  = VALUE_BITS + CNT_W;
  localparam int CMP_W  = (SUM_W > mert_pkg::TARGET_W) ? SUM_W : mert_pkg::TARGET_W;
  localparam int DIFF_W = CMP_W + 1;

  logic [VALUE_BITS-1:0] mem [MAX_LEN];
  logic [VALUE_BITS-1:0] rdata_r;
  logic [ADDR_W-1:0]     rd_addr;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [SUM_W-1:0] total_r, total_nxt;
  logic             ovf_r, ovf_nxt;
  logic [SUM_W-1:0] goal_r, goal_nxt;
  logic [CNT_W-1:0] start_r, start_nxt;
  logic [CNT_W-1:0] end_r, end_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [CNT_W-1:0] best_r, best_nxt;
  logic             found_r, found_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [1:0]       out_status_r, out_status_nxt;
  logic [CNT_W-1:0] out_rem_r, out_rem_nxt;

  logic [DIFF_W-1:0] diff;
  logic [CNT_W-1:0]  end_inc;
  logic [CNT_W-1:0]  run_len;
  logic              full;
  logic              start_le_end;
  logic              match;

  assign full         = (count_r == CNT_W'(MAX_LEN));
  assign diff         = DIFF_W'(total_r) - DIFF_W'(target_removal);
  assign end_inc      = end_r + CNT_W'(1);
  assign run_len      = end_inc - start_r;
  assign start_le_end = (start_r <= end_r);
  assign match        = start_le_end && (sum_r == goal_r);

  assign sts.overflow      = ovf_r;
  assign sts.total_lt      = diff[DIFF_W-1];
  assign sts.total_eq      = (diff == '0);
  assign sts.shrink_needed = (sum_r > goal_r) && start_le_end;
  assign sts.end_last      = (end_inc == count_r);
  assign sts.out_free      = !out_valid_r || out_ready;

  // read port address
  always_comb begin
    if (cmd.shrink_rd) begin
      rd_addr = start_r[ADDR_W-1:0];
    end else if (cmd.init) begin
      rd_addr = '0;
    end else begin
      rd_addr = end_inc[ADDR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store && !full) begin
      mem[count_r[ADDR_W-1:0]] <= element_value;
    end
    rdata_r <= mem[rd_addr];
  end

  always_comb begin
    count_nxt      = count_r;
    total_nxt      = total_r;
    ovf_nxt        = ovf_r;
    goal_nxt       = goal_r;
    start_nxt      = start_r;
    end_nxt        = end_r;
    sum_nxt        = sum_r;
    best_nxt       = best_r;
    found_nxt      = found_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_rem_nxt    = out_rem_r;

    if (cmd.store) begin
      if (full) begin
        ovf_nxt = 1'b1;
      end else begin
        count_nxt = count_r + CNT_W'(1);
        total_nxt = total_r + SUM_W'(element_value);
      end
    end
    if (cmd.init) begin
      goal_nxt  = diff[SUM_W-1:0];
      start_nxt = '0;
      end_nxt   = '0;
      sum_nxt   = '0;
      best_nxt  = '0;
      found_nxt = 1'b0;
    end
    if (cmd.add) begin
      sum_nxt = sum_r + SUM_W'(rdata_r);
    end
    if (cmd.shrink) begin
      sum_nxt   = sum_r - SUM_W'(rdata_r);
      start_nxt = start_r + CNT_W'(1);
    end
    if (cmd.advance) begin
      if (match && (!found_r || run_len > best_r)) begin
        best_nxt  = run_len;
        found_nxt = 1'b1;
      end
      end_nxt = end_inc;
    end
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
      case (cmd.kind)
        mert_pkg::EMIT_OVF: begin
          out_status_nxt = mert_pkg::ST_OVERFLOW;
          out_rem_nxt    = '0;
        end
        mert_pkg::EMIT_ALL: begin
          out_status_nxt = mert_pkg::ST_OK;
          out_rem_nxt    = count_r;
        end
        mert_pkg::EMIT_WALK: begin
          out_status_nxt = found_r ? mert_pkg::ST_OK : mert_pkg::ST_IMPOSSIBLE;
          out_rem_nxt    = found_r ? (count_r - best_r) : '0;
        end
        default: begin
          out_status_nxt = mert_pkg::ST_IMPOSSIBLE;
          out_rem_nxt    = '0;
        end
      endcase
      // set state cleared for the next set
      count_nxt = '0;
      total_nxt = '0;
      ovf_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      total_r     <= '0;
      ovf_r       <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      total_r     <= total_nxt;
      ovf_r       <= ovf_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    goal_r       <= goal_nxt;
    start_r      <= start_nxt;
    end_r        <= end_nxt;
    sum_r        <= sum_nxt;
    best_r       <= best_nxt;
    out_status_r <= out_status_nxt;
    out_rem_r    <= out_rem_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_removals = out_rem_r;

endmodule

### rtl/min_end_removals_to_target_top.sv
// top level of the min end removals block: config register, stream ports
// depends on mert_pkg, mert_ctrl, mert_dp and the defines header
//
// A set of elements streams in, one per transaction, and ends at the
// transaction with tlast high. Elements go into an on-chip store of MAX_LEN
// entries while their total is kept. After the last element the block
// reports the fewest elements that must be taken off the two ends so that
// they sum exactly to target_removal: status 0 with the count, 1 when no
// such removal exists, 2 when more than MAX_LEN elements arrived (the extra
// ones are dropped). The search walks a window over the store through its
// single read port: a decision step, then add and check steps as the window
// end passes each element and shrink and check steps as its start does; the
// result is registered once the output is free. No element is taken while
// the search runs; the next set may start loading while the result still
// waits on the output. The user must write the target over the config port
// only while no set is in progress; the block itself does not enforce it.
`include "min_end_removals_to_target_top_defines.svh"
module min_end_removals_to_target_top #(
  parameter int MAX_LEN    = mert_pkg::MAX_LEN_DEF,
  parameter int VALUE_BITS = mert_pkg::VALUE_BITS_DEF,
  localparam int CNT_W     = $clog2(MAX_LEN + 1),
  localparam int IN_DW     = ((VALUE_BITS + 7) / 8) * 8,
  localparam int OUT_DW    = ((CNT_W + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst_n,
  // input stream
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_DW-1:0]  in_tdata,   // element_value, zero padding above
  input  logic              in_tlast,   // last_item
  // result stream
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_DW-1:0] out_tdata,  // min_removals, zero padding above
  output logic [1:0]        out_tuser,  // status
  // config port
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [2:0]        cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  logic [mert_pkg::TARGET_W-1:0] target_r, target_nxt;
  logic                          cfg_wr;

  mert_pkg::mert_cmd_t cmd;
  mert_pkg::mert_sts_t sts;
  logic [CNT_W-1:0]    removals;

  // config register, address bits below the word are ignored
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                      && (cfg_paddr[2] == mert_pkg::REG_TARGET);
  assign target_nxt = cfg_wr ? cfg_pwdata[mert_pkg::TARGET_W-1:0] : target_r;
  assign cfg_prdata = (cfg_paddr[2] == mert_pkg::REG_TARGET)
                      ? 32'(target_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= mert_pkg::TARGET_W'(1);
    end else begin
      target_r <= target_nxt;
    end
  end

  // sequencer
  mert_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tlast  (in_tlast),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // store, window arithmetic and output register
  mert_dp #(
    .MAX_LEN    (MAX_LEN),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .element_value  (in_tdata[VALUE_BITS-1:0]),
    .target_removal (target_r),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .out_status     (out_tuser),
    .out_removals   (removals)
  );

  assign out_tdata = OUT_DW'(removals);

  // the set closes: no element taken while the search runs
  `MERT_ASSERT(a_busy_after_last, in_tvalid && in_tready && in_tlast |=> !in_tready)
  // status is always a defined code
  `MERT_ASSERT(a_status_code, out_tvalid |-> (out_tuser == mert_pkg::ST_OK ||
    out_tuser == mert_pkg::ST_IMPOSSIBLE || out_tuser == mert_pkg::ST_OVERFLOW))
  // removal count only accompanies a solution
  `MERT_ASSERT(a_rem_zero, out_tvalid && out_tuser != mert_pkg::ST_OK |-> out_tdata == '0)

endmodule
